// ===== rtl/four_servo_slew_ramp_assert.svh =====
// Assertion shorthands for the RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef FOUR_SERVO_SLEW_RAMP_ASSERT_SVH
`define FOUR_SERVO_SLEW_RAMP_ASSERT_SVH

// Same-cycle implication.
`define FSSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fssr assertion failed");

// Next-cycle implication.
`define FSSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fssr assertion failed");

`endif

// ===== rtl/fssr_pkg.sv =====
`timescale 1ns / 1ps
package fssr_pkg;

   localparam int CHANNELS     = 4;
   localparam int ANGLE_W      = 8;
   localparam int STEP_W       = 5;
   localparam int PULSE_W      = 12;
   localparam int TICKS_W      = 10;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 12;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SETTLE_TICKS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_OFFSET = 1'd1;

   localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 10'd100;
   localparam logic [PULSE_W-1:0] PULSE_OFFSET_RST = 12'd500;

   // 37/5 degrees-to-counts: 37*a then divide by 5 via *13108 >> 16
   localparam int SCALED_W = 14;
   localparam logic [SCALED_W-1:0] RECIP_5 = 14'd13108;
   localparam int RECIP_SHIFT = 16;
   localparam int QUOT_W = 11;
   localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

   typedef struct packed {
      logic               enable;
      logic [ANGLE_W-1:0] target_a;
      logic [ANGLE_W-1:0] target_b;
      logic [ANGLE_W-1:0] target_c;
      logic [ANGLE_W-1:0] target_d;
      logic [STEP_W-1:0]  step_a;
      logic [STEP_W-1:0]  step_b;
      logic [STEP_W-1:0]  step_c;
      logic [STEP_W-1:0]  step_d;
   } fssr_req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_a;
      logic [PULSE_W-1:0] pulse_b;
      logic [PULSE_W-1:0] pulse_c;
      logic [PULSE_W-1:0] pulse_d;
      logic               settled_pulse;
      logic               moving;
   } fssr_rsp_type;

   // per-tick control into the settle counter
   typedef struct packed {
      logic advance;
      logic enable;
      logic all_equal;
   } fssr_tick_type;

endpackage

// ===== rtl/fssr_ifs.sv =====
`timescale 1ns / 1ps
interface fssr_req_if;
   import fssr_pkg::*;
   logic         valid;
   logic         ready;
   fssr_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fssr_rsp_if;
   import fssr_pkg::*;
   logic         valid;
   logic         ready;
   fssr_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/four_servo_slew_ramp.sv =====
`timescale 1ns / 1ps
// Four-channel servo slew limiter with PWM compare outputs.
// req_stream (valid/ready) carries one control tick per item: enable, four
// target angles and four per-tick step sizes. rsp_stream returns one item per
// tick: four 12-bit compare values (offset + floor(37*angle/5), saturated),
// a one-tick settled flag and a moving flag.
// csr_we/csr_addr/csr_wdata write settle_ticks (index 0) and pulse_offset
// (index 1); write only while no item is in flight.
// A tick accepted into the input register moves to the result register and
// is presented on rsp_stream from there. Throughput: one item per cycle while
// rsp is not stalled; the slew compare/add and the constant multiply for the
// pulse width sit between the input register and the result register.
// Reset (synchronous, active high): angles and settle count to zero,
// settle_ticks to 100, pulse_offset to 500, both stages empty.
// When the receiver stalls, the result holds in its register and the input
// register still fills once; after that req ready drops until rsp moves.
module four_servo_slew_ramp (
   input  logic                                clock,
   input  logic                                reset,
   fssr_req_if.sink                            req_stream,
   fssr_rsp_if.source                          rsp_stream,
   input  logic                                csr_we,
   input  logic [fssr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [fssr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fssr_pkg::*;

   // config registers
   logic [TICKS_W-1:0]  settle_ticks_ff;
   logic [PULSE_W-1:0]  pulse_offset_ff;

   // input stage
   logic                in_valid_ff;
   fssr_req_type        in_data_ff;

   // result stage
   logic                out_valid_ff;
   fssr_rsp_type        out_data_ff;
   fssr_rsp_type        out_data_in;

   logic                out_load;
   logic                advance;

   logic [ANGLE_W-1:0]  target_arr [CHANNELS];
   logic [STEP_W-1:0]   step_arr   [CHANNELS];
   logic [PULSE_W-1:0]  pulse_arr  [CHANNELS];
   logic [CHANNELS-1:0] equal_vec;

   fssr_tick_type       tick;
   logic                settle_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= SETTLE_TICKS_RST;
         pulse_offset_ff <= PULSE_OFFSET_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SETTLE_TICKS: settle_ticks_ff <= csr_wdata[TICKS_W-1:0];
            REG_PULSE_OFFSET: pulse_offset_ff <= csr_wdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // result register loads when empty or being drained
   assign out_load         = !out_valid_ff || rsp_stream.ready;
   assign advance          = in_valid_ff && out_load;
   assign req_stream.ready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_stream.ready) begin
         in_valid_ff <= req_stream.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_stream.valid && req_stream.ready) begin
         in_data_ff <= req_stream.data;
      end
   end

   // fan the tick out into per-channel lanes
   assign target_arr[0] = in_data_ff.target_a;
   assign target_arr[1] = in_data_ff.target_b;
   assign target_arr[2] = in_data_ff.target_c;
   assign target_arr[3] = in_data_ff.target_d;
   assign step_arr[0]   = in_data_ff.step_a;
   assign step_arr[1]   = in_data_ff.step_b;
   assign step_arr[2]   = in_data_ff.step_c;
   assign step_arr[3]   = in_data_ff.step_d;

   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      fssr_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .enable       (in_data_ff.enable),
         .target       (target_arr[k]),
         .step         (step_arr[k]),
         .pulse_offset (pulse_offset_ff),
         .pulse        (pulse_arr[k]),
         .at_target    (equal_vec[k])
      );
   end

   assign tick.advance   = advance;
   assign tick.enable    = in_data_ff.enable;
   assign tick.all_equal = &equal_vec;

   fssr_settle u_settle (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick),
      .settle_ticks (settle_ticks_ff),
      .fire         (settle_fire)
   );

   always_comb begin
      out_data_in.pulse_a       = pulse_arr[0];
      out_data_in.pulse_b       = pulse_arr[1];
      out_data_in.pulse_c       = pulse_arr[2];
      out_data_in.pulse_d       = pulse_arr[3];
      out_data_in.settled_pulse = settle_fire;
      out_data_in.moving        = !tick.all_equal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_stream.valid = out_valid_ff;
   assign rsp_stream.data  = out_data_ff;

endmodule

// ===== rtl/fssr_lane.sv =====
`timescale 1ns / 1ps
module fssr_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            enable,
   input  logic [fssr_pkg::ANGLE_W-1:0]    target,
   input  logic [fssr_pkg::STEP_W-1:0]     step,
   input  logic [fssr_pkg::PULSE_W-1:0]    pulse_offset,
   output logic [fssr_pkg::PULSE_W-1:0]    pulse,
   output logic                            at_target
);
   import fssr_pkg::*;

   logic [ANGLE_W-1:0]            angle_ff;
   logic [ANGLE_W-1:0]            angle_in;
   logic [ANGLE_W-1:0]            angle_new;
   logic [ANGLE_W:0]              up_sum;
   logic [ANGLE_W-1:0]            down_gap;
   logic [SCALED_W-1:0]           scaled;
   logic [2*SCALED_W-1:0]         product;
   logic [QUOT_W-1:0]             quot;
   logic [PULSE_W:0]              pulse_sum;

   // one slew step toward target, clamped at target both ways
   always_comb begin
      up_sum   = {1'b0, angle_ff} + {{(ANGLE_W+1-STEP_W){1'b0}}, step};
      down_gap = angle_ff - target;
      if (angle_ff < target) begin
         angle_new = (up_sum > {1'b0, target}) ? target : up_sum[ANGLE_W-1:0];
      end else if (angle_ff > target) begin
         angle_new = ({{(ANGLE_W-STEP_W){1'b0}}, step} >= down_gap) ? target
                   : angle_ff - {{(ANGLE_W-STEP_W){1'b0}}, step};
      end else begin
         angle_new = angle_ff;
      end
      angle_in = enable ? angle_new : angle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
      end else if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign at_target = (angle_in == target);

   // 37*angle, then floor(/5) by reciprocal; exact for 37*angle <= 9435
   always_comb begin
      scaled    = {1'b0, angle_in, 5'b0} + {4'b0, angle_in, 2'b0}
                + {{(SCALED_W-ANGLE_W){1'b0}}, angle_in};
      product   = scaled * RECIP_5;
      quot      = product[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      pulse_sum = {1'b0, pulse_offset} + {{(PULSE_W+1-QUOT_W){1'b0}}, quot};
      pulse     = pulse_sum[PULSE_W] ? PULSE_MAX : pulse_sum[PULSE_W-1:0];
   end

endmodule

// ===== rtl/fssr_settle.sv =====
`timescale 1ns / 1ps
`include "four_servo_slew_ramp_assert.svh"
module fssr_settle (
   input  logic                            clock,
   input  logic                            reset,
   input  fssr_pkg::fssr_tick_type         tick,
   input  logic [fssr_pkg::TICKS_W-1:0]    settle_ticks,
   output logic                            fire
);
   import fssr_pkg::*;

   logic [TICKS_W-1:0] count_ff;
   logic [TICKS_W-1:0] count_in;
   logic [TICKS_W:0]   count_next;
   logic               counting;

   // count is formed one bit wider so settle_ticks of 1023 fires at 1024
   always_comb begin
      counting   = tick.enable && tick.all_equal;
      count_next = {1'b0, count_ff} + {{TICKS_W{1'b0}}, 1'b1};
      fire       = counting && (count_next > {1'b0, settle_ticks});
      if (fire) begin
         count_in = '0;
      end else if (counting) begin
         count_in = count_next[TICKS_W-1:0];
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (tick.advance) begin
         count_ff <= count_in;
      end
   end

   `FSSR_ASSERT_NEXT(a_fire_clears, clock, reset, tick.advance && fire, count_ff == '0)
   `FSSR_ASSERT_NEXT(a_hold_idle, clock, reset, !tick.advance, $stable(count_ff))
   `FSSR_ASSERT_NOW(a_fire_needs_settle, clock, reset, fire, tick.enable && tick.all_equal)

endmodule

// ===== test/tb_four_servo_slew_ramp.sv =====
`timescale 1ns / 1ps
module tb_four_servo_slew_ramp;
   import fssr_pkg::*;

   localparam int CYCLE_LIMIT    = 100000;
   localparam int STALL_AT_TICK  = 120;   // receiver hold-off starts after this many items
   localparam int STALL_CYCLES   = 150;
   localparam int REPORT_MAX     = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fssr_req_if req_bus ();
   fssr_rsp_if rsp_bus ();

   four_servo_slew_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_bus),
      .rsp_stream (rsp_bus),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ticks waiting to be offered, and servo results waiting to come back
   fssr_req_type tick_plan[$];
   fssr_rsp_type pending_rsp[$];

   int cycle_count = 0;
   int ticks_taken = 0;
   int mismatches  = 0;
   int stall_left  = 0;
   logic stall_done = 1'b0;

   // servo model: angles, settle counter and the two registers
   logic [ANGLE_W-1:0] angle_q[CHANNELS] = '{default: '0};
   logic [TICKS_W-1:0] settle_cnt  = '0;
   logic [TICKS_W-1:0] ticks_limit = SETTLE_TICKS_RST;
   logic [PULSE_W-1:0] offset_reg  = PULSE_OFFSET_RST;

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Servo model
   // ------------------------------------------------------------------

   // Move toward the target by at most stp; never passes it either way.
   function automatic logic [ANGLE_W-1:0] slew_toward(logic [ANGLE_W-1:0] cur,
                                                       logic [ANGLE_W-1:0] tgt,
                                                       logic [STEP_W-1:0] stp);
      logic [ANGLE_W:0]   up;
      logic [ANGLE_W-1:0] stp_w;
      stp_w = {{(ANGLE_W-STEP_W){1'b0}}, stp};
      up = {1'b0, cur} + {1'b0, stp_w};
      if (cur < tgt) begin
         return (up > {1'b0, tgt}) ? tgt : up[ANGLE_W-1:0];
      end else if (cur > tgt) begin
         return (stp_w >= cur - tgt) ? tgt : cur - stp_w;
      end
      return cur;
   endfunction

   // offset + floor(37*angle/5), saturated to the 12-bit compare range
   function automatic logic [PULSE_W-1:0] pulse_width(logic [ANGLE_W-1:0] a);
      int p;
      p = int'(offset_reg) + (37 * int'(a)) / 5;
      return (p > int'(PULSE_MAX)) ? PULSE_MAX : p[PULSE_W-1:0];
   endfunction

   // One control tick: update the model state and return the servo result.
   function automatic fssr_rsp_type servo_tick(fssr_req_type t);
      logic [ANGLE_W-1:0] tg[CHANNELS];
      logic [STEP_W-1:0]  sp[CHANNELS];
      logic               all_eq;
      logic [TICKS_W:0]   nxt;
      fssr_rsp_type       r;
      tg = '{t.target_a, t.target_b, t.target_c, t.target_d};
      sp = '{t.step_a, t.step_b, t.step_c, t.step_d};
      all_eq = 1'b1;
      r.settled_pulse = 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
         if (t.enable) angle_q[k] = slew_toward(angle_q[k], tg[k], sp[k]);
         if (angle_q[k] != tg[k]) all_eq = 1'b0;
      end
      // not-settled and disabled ticks leave the counter alone
      if (t.enable && all_eq) begin
         nxt = {1'b0, settle_cnt} + (TICKS_W+1)'(1);
         if (nxt > {1'b0, ticks_limit}) begin
            r.settled_pulse = 1'b1;
            settle_cnt = '0;
         end else begin
            settle_cnt = nxt[TICKS_W-1:0];
         end
      end
      r.pulse_a = pulse_width(angle_q[0]);
      r.pulse_b = pulse_width(angle_q[1]);
      r.pulse_c = pulse_width(angle_q[2]);
      r.pulse_d = pulse_width(angle_q[3]);
      r.moving  = ~all_eq;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Error reporting
   // ------------------------------------------------------------------

   task automatic flag_error(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [PULSE_W-1:0] want,
                              logic [PULSE_W-1:0] got);
      if (got !== want)
         flag_error($sformatf("item %0d %s: expected %0d, got %0d",
                              ticks_taken, name, want, got));
   endtask

   // ------------------------------------------------------------------
   // Idling: a 27 percent chance on each call, except in a quiet window where both
   // sides run flat out.
   // ------------------------------------------------------------------
   function automatic logic take_break();
      if ((cycle_count % 3000) >= 2300) return 1'b0;
      return $urandom_range(0, 99) < 27;
   endfunction

   // ------------------------------------------------------------------
   // Driver: holds an offered item until accepted, then takes the next
   // one from tick_plan or idles.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (tick_plan.size() != 0 && !take_break()) begin
            req_bus.valid <= 1'b1;
            req_bus.data  <= tick_plan.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on every accepted tick, checks every accepted
   // result in order. Prediction and check share one process so the
   // result store is never touched by two processes in one edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      fssr_rsp_type want;
      fssr_rsp_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_rsp.push_back(servo_tick(req_bus.data));
            ticks_taken <= ticks_taken + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (pending_rsp.size() == 0) begin
               flag_error("result item with nothing expected");
            end else begin
               want = pending_rsp.pop_front();
               check_field("pulse_a", want.pulse_a, got.pulse_a);
               check_field("pulse_b", want.pulse_b, got.pulse_b);
               check_field("pulse_c", want.pulse_c, got.pulse_c);
               check_field("pulse_d", want.pulse_d, got.pulse_d);
               check_field("settled_pulse", PULSE_W'(want.settled_pulse),
                           PULSE_W'(got.settled_pulse));
               check_field("moving", PULSE_W'(want.moving), PULSE_W'(got.moving));
            end
         end
         rsp_bus.ready <= (stall_left == 0) && !take_break();
      end
   end

   // Long receiver hold-off, once: the sender keeps offering so the block
   // fills its two stages and drops req ready.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (ticks_taken == STALL_AT_TICK && !stall_done) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("four_servo_slew_ramp test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   task automatic add_tick(logic en,
                           logic [ANGLE_W-1:0] ta, logic [ANGLE_W-1:0] tb,
                           logic [ANGLE_W-1:0] tc, logic [ANGLE_W-1:0] td,
                           logic [STEP_W-1:0] sa, logic [STEP_W-1:0] sb,
                           logic [STEP_W-1:0] sc, logic [STEP_W-1:0] sd);
      fssr_req_type t;
      t.enable   = en;
      t.target_a = ta;
      t.target_b = tb;
      t.target_c = tc;
      t.target_d = td;
      t.step_a   = sa;
      t.step_b   = sb;
      t.step_c   = sc;
      t.step_d   = sd;
      tick_plan.push_back(t);
   endtask

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [ANGLE_W-1:0] rand_angle();
      return ANGLE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [STEP_W-1:0] rand_step();
      return STEP_W'($urandom_range(0, 31));
   endfunction

   // targets lean on the ends of the range
   function automatic logic [ANGLE_W-1:0] pick_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return '0;
      if (r < 25) return '1;
      return rand_angle();
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return STEP_W'($urandom_range(1, 30));
   endfunction

   // Mostly ramp sequences: fixed targets held for a run of ticks so the
   // channels arrive and settle; the rest is fully random noise.
   task automatic gen_traffic(int n);
      logic [ANGLE_W-1:0] tg[CHANNELS];
      logic [STEP_W-1:0]  sp[CHANNELS];
      int left;
      int run;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 15) begin
            add_tick(rand_bit(),
                     rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                     rand_step(), rand_step(), rand_step(), rand_step());
            left--;
         end else begin
            for (int k = 0; k < CHANNELS; k++) begin
               tg[k] = pick_target();
               sp[k] = pick_step();
            end
            run = $urandom_range(1, 24);
            for (int j = 0; j < run && left > 0; j++) begin
               if ($urandom_range(0, 1))
                  for (int k = 0; k < CHANNELS; k++) sp[k] = pick_step();
               add_tick($urandom_range(0, 99) >= 8, tg[0], tg[1], tg[2], tg[3],
                        sp[0], sp[1], sp[2], sp[3]);
               left--;
            end
         end
      end
   endtask

   // Park on one pose and stay there, so the settle counter climbs all the
   // way to the top of its range; disabled noise ticks do not clear it.
   task automatic gen_parked(int n);
      logic [ANGLE_W-1:0] tg[CHANNELS];
      for (int k = 0; k < CHANNELS; k++) tg[k] = rand_angle();
      // full-rate steps: any start angle arrives within nine ticks
      repeat (10) add_tick(1'b1, tg[0], tg[1], tg[2], tg[3], 5'd31, 5'd31, 5'd31, 5'd31);
      for (int j = 10; j < n; j++) begin
         if ($urandom_range(0, 99) < 6)
            add_tick(1'b0, rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                     rand_step(), rand_step(), rand_step(), rand_step());
         else
            add_tick(1'b1, tg[0], tg[1], tg[2], tg[3],
                     rand_step(), rand_step(), rand_step(), rand_step());
      end
   endtask

   // Wait until every tick is accepted and every result checked, then let
   // the two-stage pipeline run dry.
   task automatic wait_drained();
      do @(negedge clock);
      while (tick_plan.size() != 0 || req_bus.valid || pending_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Register write; the model takes the new value as the write is set up, ahead of the DUT register.
   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         REG_SETTLE_TICKS: ticks_limit = val[TICKS_W-1:0];
         REG_PULSE_OFFSET: offset_reg  = val[PULSE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset register values (settle 100, offset 500).
      // disabled tick: nothing moves, pulses from the held zero angles
      add_tick(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 5'd31, 5'd31, 5'd31, 5'd31);
      // full ramp up to the top angle; arrives on the ninth tick
      repeat (9) add_tick(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 5'd31, 5'd31, 5'd31, 5'd31);
      // zero steps while on target: still settled
      add_tick(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 5'd0, 5'd0, 5'd0, 5'd0);
      // a: zero step away from target; c: downward clamp onto a near target; d holds
      add_tick(1'b1, 8'd0, 8'd200, 8'd254, 8'd255, 5'd0, 5'd31, 5'd31, 5'd16);
      // b lands on 200 from below the step size; c holds
      add_tick(1'b1, 8'd0, 8'd200, 8'd254, 8'd255, 5'd31, 5'd31, 5'd1, 5'd1);
      add_tick(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 5'd31, 5'd5, 5'd31, 5'd31);
      add_tick(1'b0, 8'd17, 8'd3, 8'd99, 8'd128, 5'd31, 5'd31, 5'd31, 5'd31);
      add_tick(1'b1, 8'd0, 8'd1, 8'd2, 8'd3, 5'd31, 5'd31, 5'd31, 5'd31);
      add_tick(1'b1, 8'd255, 8'd0, 8'd128, 8'd1, 5'd1, 5'd31, 5'd7, 5'd3);
      add_tick(1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 5'd31, 5'd30, 5'd29, 5'd28);
      add_tick(1'b1, 8'd128, 8'd128, 8'd128, 8'd128, 5'd31, 5'd31, 5'd31, 5'd31);
      add_tick(1'b1, 8'd128, 8'd128, 8'd128, 8'd128, 5'd16, 5'd8, 5'd4, 5'd2);
      gen_traffic(250);
      wait_drained();

      // settle threshold zero: every settled tick pulses; offset saturates
      write_reg(REG_SETTLE_TICKS, 12'd0);
      write_reg(REG_PULSE_OFFSET, 12'd4095);
      gen_traffic(200);
      wait_drained();

      // counter at the top of its range: pulse only when it would hit 1024
      write_reg(REG_SETTLE_TICKS, 12'd1023);
      write_reg(REG_PULSE_OFFSET, 12'd0);
      gen_parked(1150);
      wait_drained();

      // random middle settings; high offsets saturate only the wide angles
      write_reg(REG_SETTLE_TICKS, CSR_DATA_W'($urandom_range(1, 6)));
      write_reg(REG_PULSE_OFFSET, CSR_DATA_W'($urandom_range(2300, 4000)));
      gen_traffic(150);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("four_servo_slew_ramp test passed");
      end else begin
         $display("four_servo_slew_ramp test failed");
      end
      $finish;
   end

endmodule
